/* hdl/cfxa_pkg.sv */
// Package: widths, codes and latency figures for the complex fixed-point ALU.
package cfxa_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  localparam int PW = 2 * DATA_WIDTH;          // exact product
  localparam int SW = PW + 2;                  // signed sums and wide results
  localparam int DW = PW + 1;                  // divisor c^2 + d^2
  localparam int MW = PW + 1;                  // magnitude of a sum
  localparam int QB = DATA_WIDTH + 1;          // quotient bits kept
  localparam int NW = MW + FRAC_BITS;          // scaled dividend
  localparam int RW = (NW > DW + QB) ? NW : DW + QB;  // partial remainder

  localparam int DIV_LAT = QB + 1;             // divider latency
  localparam int LAT     = DIV_LAT + 4;        // start to strobe

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                 mode;
    logic                  zero;
    logic                  neg_re;
    logic                  neg_im;
    logic signed [SW-1:0]  xre;
    logic signed [SW-1:0]  xim;
  } side_t;

endpackage

/* hdl/cfxa_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module cfxa_div import cfxa_pkg::*; (
  input  logic          clk_i,
  input  logic [RW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quo_o,
  output logic          ovf_o
);

  logic [RW-1:0] rem_q [QB+1];
  logic [RW-1:0] rem_d [QB+1];
  logic [DW-1:0] den_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic [QB-1:0] quo_d [QB+1];
  logic          ovf_q [QB+1];

  always_comb begin
    logic [RW-1:0] trial;
    logic          ge;
    rem_d[0] = num_i;
    quo_d[0] = '0;
    for (int i = 0; i < QB; i++) begin
      trial        = RW'(den_q[i]) << (QB - 1 - i);
      ge           = (rem_q[i] >= trial);
      rem_d[i+1]   = ge ? rem_q[i] - trial : rem_q[i];
      quo_d[i+1]   = quo_q[i] | (QB'(ge) << (QB - 1 - i));
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= rem_d[0];
    quo_q[0] <= quo_d[0];
    den_q[0] <= den_i;
    ovf_q[0] <= (num_i >= (RW'(den_i) << QB));
    for (int i = 1; i <= QB; i++) begin
      rem_q[i] <= rem_d[i];
      quo_q[i] <= quo_d[i];
      den_q[i] <= den_q[i-1];
      ovf_q[i] <= ovf_q[i-1];
    end
  end

  assign quo_o = quo_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule

/* hdl/complex_fixed_point_alu_top.sv */
// Top level of the complex fixed-point ALU: add, subtract, multiply, divide.
//
// Channel  Direction  Handshake               Payload
// command  in         start_i & !busy_o       mode_i, a_re_i, a_im_i, b_re_i, b_im_i
// result   out        strobe_o (one cycle)    res_re_o, res_im_o, status_o
//
// Data is Q8.8. Every transaction runs from start to strobe through a pipeline
// whose depth is set by the divider: one quotient bit per stage over DATA_WIDTH+1
// stages. A new transaction is taken every cycle; busy_o stays low.
// Reset clears only the valid chain; payload registers are not reset.
// The receiver cannot stall, so nothing in the pipe ever holds.
module complex_fixed_point_alu_top import cfxa_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   mode_i,
  input  logic signed [DATA_WIDTH-1:0] a_re_i,
  input  logic signed [DATA_WIDTH-1:0] a_im_i,
  input  logic signed [DATA_WIDTH-1:0] b_re_i,
  input  logic signed [DATA_WIDTH-1:0] b_im_i,
  output logic                         strobe_o,
  output logic signed [DATA_WIDTH-1:0] res_re_o,
  output logic signed [DATA_WIDTH-1:0] res_im_o,
  output logic [1:0]                   status_o
);

  localparam logic signed [SW-1:0] MAXP =
    {{(SW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] MINN = ~MAXP;

  // valid chain, one bit per stage
  logic [LAT-1:0] vld_q, vld_d;

  // stage 1: products and plain sums
  mode_e                mode1_q;
  logic                 zero1_q;
  logic signed [PW-1:0] pac_q, pbd_q, pad_q, pbc_q, pcc_q, pdd_q;
  logic signed [SW-1:0] asr_q, asi_q, asr_d, asi_d;

  // stage 2: combined sums and divisor
  mode_e                mode2_q;
  logic                 zero2_q;
  logic signed [SW-1:0] sre2_q, sim2_q, sre2_d, sim2_d;
  logic [DW-1:0]        den2_q;

  // stage 3: magnitudes for the divider, finished values otherwise
  logic [RW-1:0]        num_re3_q, num_im3_q;
  logic [DW-1:0]        den3_q;
  side_t                side3_q, side3_d;
  logic [SW-1:0]        mag_re, mag_im;

  // side data riding along with the divider
  side_t                side_q [DIV_LAT];
  side_t                side_f;

  logic [QB-1:0]        quo_re, quo_im;
  logic                 ovf_re, ovf_im;

  // output stage
  logic signed [SW-1:0]         val_re, val_im;
  logic signed [DATA_WIDTH-1:0] res_re_d, res_im_d, res_re_q, res_im_q;
  status_e                      status_d, status_q;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[LAT-2:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1
  always_comb begin
    if (mode_e'(mode_i) == MODE_SUB) begin
      asr_d = SW'(a_re_i) - SW'(b_re_i);
      asi_d = SW'(a_im_i) - SW'(b_im_i);
    end else begin
      asr_d = SW'(a_re_i) + SW'(b_re_i);
      asi_d = SW'(a_im_i) + SW'(b_im_i);
    end
  end

  always_ff @(posedge clk_i) begin
    mode1_q <= mode_e'(mode_i);
    zero1_q <= (b_re_i == '0) && (b_im_i == '0);
    pac_q   <= PW'(a_re_i) * PW'(b_re_i);
    pbd_q   <= PW'(a_im_i) * PW'(b_im_i);
    pad_q   <= PW'(a_re_i) * PW'(b_im_i);
    pbc_q   <= PW'(a_im_i) * PW'(b_re_i);
    pcc_q   <= PW'(b_re_i) * PW'(b_re_i);
    pdd_q   <= PW'(b_im_i) * PW'(b_im_i);
    asr_q   <= asr_d;
    asi_q   <= asi_d;
  end

  // stage 2
  always_comb begin
    case (mode1_q)
      MODE_MUL: begin
        sre2_d = SW'(pac_q) - SW'(pbd_q);
        sim2_d = SW'(pad_q) + SW'(pbc_q);
      end
      MODE_DIV: begin
        sre2_d = SW'(pac_q) + SW'(pbd_q);
        sim2_d = SW'(pbc_q) - SW'(pad_q);
      end
      default: begin
        sre2_d = asr_q;
        sim2_d = asi_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mode2_q <= mode1_q;
    zero2_q <= zero1_q;
    sre2_q  <= sre2_d;
    sim2_q  <= sim2_d;
    den2_q  <= DW'($unsigned(pcc_q)) + DW'($unsigned(pdd_q));
  end

  // stage 3: sign split; the multiply shift is a floor on the exact sum
  always_comb begin
    mag_re         = sre2_q[SW-1] ? $unsigned(-sre2_q) : $unsigned(sre2_q);
    mag_im         = sim2_q[SW-1] ? $unsigned(-sim2_q) : $unsigned(sim2_q);
    side3_d.mode   = mode2_q;
    side3_d.zero   = zero2_q;
    side3_d.neg_re = sre2_q[SW-1];
    side3_d.neg_im = sim2_q[SW-1];
    if (mode2_q == MODE_MUL) begin
      side3_d.xre = sre2_q >>> FRAC_BITS;
      side3_d.xim = sim2_q >>> FRAC_BITS;
    end else begin
      side3_d.xre = sre2_q;
      side3_d.xim = sim2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_re3_q <= RW'(mag_re) << FRAC_BITS;
    num_im3_q <= RW'(mag_im) << FRAC_BITS;
    den3_q    <= den2_q;
    side3_q   <= side3_d;
  end

  cfxa_div u_div_re (
    .clk_i (clk_i),
    .num_i (num_re3_q),
    .den_i (den3_q),
    .quo_o (quo_re),
    .ovf_o (ovf_re)
  );

  cfxa_div u_div_im (
    .clk_i (clk_i),
    .num_i (num_im3_q),
    .den_i (den3_q),
    .quo_o (quo_im),
    .ovf_o (ovf_im)
  );

  always_ff @(posedge clk_i) begin
    side_q[0] <= side3_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  assign side_f = side_q[DIV_LAT-1];

  // final stage: quotient sign, saturation, status
  always_comb begin
    logic sat;
    logic signed [SW-1:0] qre, qim;
    qre = ovf_re ? SW'({1'b1, {QB{1'b0}}}) : SW'(quo_re);
    qim = ovf_im ? SW'({1'b1, {QB{1'b0}}}) : SW'(quo_im);
    if (side_f.mode == MODE_DIV) begin
      val_re = side_f.neg_re ? -qre : qre;
      val_im = side_f.neg_im ? -qim : qim;
    end else begin
      val_re = side_f.xre;
      val_im = side_f.xim;
    end
    sat = 1'b0;
    if (val_re > MAXP) begin
      res_re_d = DATA_WIDTH'(MAXP);
      sat      = 1'b1;
    end else if (val_re < MINN) begin
      res_re_d = DATA_WIDTH'(MINN);
      sat      = 1'b1;
    end else begin
      res_re_d = DATA_WIDTH'(val_re);
    end
    if (val_im > MAXP) begin
      res_im_d = DATA_WIDTH'(MAXP);
      sat      = 1'b1;
    end else if (val_im < MINN) begin
      res_im_d = DATA_WIDTH'(MINN);
      sat      = 1'b1;
    end else begin
      res_im_d = DATA_WIDTH'(val_im);
    end
    status_d = sat ? ST_SAT : ST_OK;
    if (side_f.mode == MODE_DIV && side_f.zero) begin
      res_re_d = '0;
      res_im_d = '0;
      status_d = ST_DIV0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_re_q <= res_re_d;
    res_im_q <= res_im_d;
    status_q <= status_d;
  end

  assign strobe_o = vld_q[LAT-1];
  assign res_re_o = res_re_q;
  assign res_im_o = res_im_q;
  assign status_o = status_q;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT strobe_o)
    else $error("transaction did not reach the result port on time");

  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && status_o == ST_DIV0) |-> (res_re_o == '0 && res_im_o == '0))
    else $error("divide-by-zero result is not zero");

  a_div0_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && mode_i == MODE_DIV && b_re_i == '0 && b_im_i == '0)
      |-> ##LAT (status_o == ST_DIV0))
    else $error("zero divisor not flagged");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start_i, LAT))
    else $error("result strobe without a transaction");
`endif

endmodule
